/* hw/rtl/gasb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasb_pkg
// Shared constants and types of the glyph atlas shelf blitter.
// ----------------------------------------------------------------------------
package gasb_pkg;

   localparam int ATLAS_SIDE = 512;     // square atlas side in pixels
   localparam int DIM_W      = 10;      // size, cursor and coordinate width
   localparam int ORG_W      = 9;       // reported origin width
   localparam int ALPHA_W    = 8;
   localparam int SUM_W      = 13;      // wide enough for y + h + r at any side
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ALPHA_W-1:0] SOFT_LIMIT = ALPHA_W'(16);
   localparam logic [SUM_W-1:0]   SIDE_SUM   = SUM_W'(ATLAS_SIDE);

   typedef struct packed {
      logic [DIM_W-1:0]   pixel_x;
      logic [DIM_W-1:0]   pixel_y;
      logic [ALPHA_W-1:0] soft_alpha;
      logic [ORG_W-1:0]   origin_x;
      logic [ORG_W-1:0]   origin_y;
      logic               no_room;
      logic               glyph_done;
   } result_type;

   // results produced by one accepted pixel, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   function automatic logic [ALPHA_W-1:0] soften(input logic [ALPHA_W-1:0] alpha,
                                                 input logic edge_hit);
      logic [ALPHA_W-1:0] res;
      res = alpha;
      if (alpha > SOFT_LIMIT && edge_hit) begin
         res = alpha >> 1;
      end
      return res;
   endfunction

endpackage

/* hw/rtl/gasb_place_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasb_place_step
// Shelf placement, pixel position tracking and edge softening for one pixel.
// ----------------------------------------------------------------------------
module gasb_place_step
   import gasb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [DIM_W-1:0]   glyph_width,
   input  logic [DIM_W-1:0]   glyph_rows,
   input  logic [ALPHA_W-1:0] coverage,
   output step_out_type       step_out
);

   logic [DIM_W-1:0]   cursor_x_ff, cursor_y_ff, shelf_height_ff;
   logic [DIM_W-1:0]   place_x_ff, place_y_ff, held_width_ff, held_rows_ff;
   logic [DIM_W-1:0]   column_count_ff, row_count_ff;
   logic [ALPHA_W-1:0] pending_alpha_ff, left_alpha_ff;
   logic               overflow_flag_ff;

   logic [DIM_W-1:0]   cursor_x_in, cursor_y_in, shelf_height_in;
   logic [DIM_W-1:0]   place_x_in, place_y_in, held_width_in, held_rows_in;
   logic [DIM_W-1:0]   column_count_in, row_count_in;
   logic [ALPHA_W-1:0] pending_alpha_in, left_alpha_in;
   logic               overflow_flag_in;

   logic [DIM_W-1:0]   w_eff, r_eff;
   logic               first_pixel;
   logic [SUM_W-1:0]   x_w_sum, y_r_sum, y_h_r_sum;
   logic [DIM_W-1:0]   new_x, new_y, new_h;
   logic               new_nr;
   logic [DIM_W-1:0]   cur_px, cur_py, cur_w, cur_r;
   logic               cur_nr;
   logic               last_col, last_row, edge_hit;
   result_type         res_held, res_last;

   always_comb begin
      w_eff = (glyph_width == '0) ? DIM_W'(1) : glyph_width;
      r_eff = (glyph_rows == '0) ? DIM_W'(1) : glyph_rows;
      first_pixel = (column_count_ff == '0) && (row_count_ff == '0);

      x_w_sum   = SUM_W'(cursor_x_ff) + SUM_W'(w_eff);
      y_r_sum   = SUM_W'(cursor_y_ff) + SUM_W'(r_eff);
      y_h_r_sum = SUM_W'(cursor_y_ff) + SUM_W'(shelf_height_ff) + SUM_W'(r_eff);

      new_x  = cursor_x_ff;
      new_y  = cursor_y_ff;
      new_h  = shelf_height_ff;
      new_nr = 1'b0;
      if (x_w_sum <= SIDE_SUM && y_r_sum <= SIDE_SUM) begin
         if (r_eff > shelf_height_ff) begin
            new_h = r_eff;
         end
      end else if (y_h_r_sum < SIDE_SUM) begin
         // open a new shelf below the current one
         new_x = '0;
         new_y = cursor_y_ff + shelf_height_ff;
         new_h = r_eff;
      end else begin
         new_nr = 1'b1;
      end

      cur_px = first_pixel ? new_x  : place_x_ff;
      cur_py = first_pixel ? new_y  : place_y_ff;
      cur_w  = first_pixel ? w_eff  : held_width_ff;
      cur_r  = first_pixel ? r_eff  : held_rows_ff;
      cur_nr = first_pixel ? new_nr : overflow_flag_ff;

      last_col = ({1'b0, column_count_ff} + 1'b1) >= {1'b0, cur_w};
      last_row = ({1'b0, row_count_ff} + 1'b1) >= {1'b0, cur_r};
      edge_hit = (column_count_ff == DIM_W'(1)) || (left_alpha_ff < SOFT_LIMIT) ||
                 (coverage < SOFT_LIMIT);

      // held pixel, released by its right neighbour
      res_held.pixel_x    = cur_px + column_count_ff - 1'b1;
      res_held.pixel_y    = cur_py + row_count_ff;
      res_held.soft_alpha = soften(pending_alpha_ff, edge_hit);
      res_held.origin_x   = cur_px[ORG_W-1:0];
      res_held.origin_y   = cur_py[ORG_W-1:0];
      res_held.no_room    = cur_nr;
      res_held.glyph_done = 1'b0;

      // pixel in the last column goes out at once
      res_last.pixel_x    = cur_px + column_count_ff;
      res_last.pixel_y    = cur_py + row_count_ff;
      res_last.soft_alpha = soften(coverage, 1'b1);
      res_last.origin_x   = cur_px[ORG_W-1:0];
      res_last.origin_y   = cur_py[ORG_W-1:0];
      res_last.no_room    = cur_nr;
      res_last.glyph_done = last_row;

      step_out.count  = 2'(column_count_ff != '0) + 2'(last_col);
      step_out.first  = (column_count_ff != '0) ? res_held : res_last;
      step_out.second = res_last;
   end

   always_comb begin
      cursor_x_in      = cursor_x_ff;
      cursor_y_in      = cursor_y_ff;
      shelf_height_in  = shelf_height_ff;
      place_x_in       = cur_px;
      place_y_in       = cur_py;
      held_width_in    = cur_w;
      held_rows_in     = cur_r;
      overflow_flag_in = cur_nr;
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      pending_alpha_in = pending_alpha_ff;
      left_alpha_in    = left_alpha_ff;
      if (first_pixel) begin
         cursor_x_in     = new_x + w_eff;
         cursor_y_in     = new_y;
         shelf_height_in = new_h;
      end
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : row_count_ff + 1'b1;
      end else begin
         left_alpha_in    = pending_alpha_ff;
         pending_alpha_in = coverage;
         column_count_in  = column_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         shelf_height_ff  <= '0;
         place_x_ff       <= '0;
         place_y_ff       <= '0;
         held_width_ff    <= '0;
         held_rows_ff     <= '0;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         pending_alpha_ff <= '0;
         left_alpha_ff    <= '0;
         overflow_flag_ff <= 1'b0;
      end else if (take) begin
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         shelf_height_ff  <= shelf_height_in;
         place_x_ff       <= place_x_in;
         place_y_ff       <= place_y_in;
         held_width_ff    <= held_width_in;
         held_rows_ff     <= held_rows_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         pending_alpha_ff <= pending_alpha_in;
         left_alpha_ff    <= left_alpha_in;
         overflow_flag_ff <= overflow_flag_in;
      end
   end

endmodule

/* hw/rtl/gasb_rsp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasb_rsp_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module gasb_rsp_queue
   import gasb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  step_out_type      step_out,
   input  logic              pop,
   output logic              room_for_two,
   output logic              head_valid,
   output result_type        head
);

   result_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, tail_ff, head_in, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic [1:0]         push_n;
   logic [QPTR_W-1:0]  tail_next;

   always_comb begin
      push_n       = push ? step_out.count : 2'd0;
      tail_next    = tail_ff + 1'b1;
      head_valid   = (count_ff != '0);
      head         = entry_ff[head_ff];
      room_for_two = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
      head_in      = pop ? head_ff + 1'b1 : head_ff;
      tail_in      = tail_ff + QPTR_W'(push_n);
      count_in     = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[tail_ff] <= step_out.first;
      end
      if (push_n == 2'd2) begin
         entry_ff[tail_next] <= step_out.second;
      end
   end

endmodule

/* hw/rtl/glyph_atlas_shelf_blit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_blit
// Shelf-packs glyphs into a square atlas and streams out softened pixels.
// ----------------------------------------------------------------------------
// Usage: glyph coverage pixels enter on the req_ stream in row-major order,
// one pixel per transfer, each carrying its glyph's width and height (only
// the first pixel of a glyph is sampled for size). The first pixel places the
// glyph on the current shelf, on a new shelf below, or flags no_room.
// Results leave on the rsp_ stream, one pixel per transfer, with atlas
// coordinates, softened alpha and glyph origin; tlast marks a glyph's last
// pixel and tuser carries no_room.
// A pixel is held until its right neighbour arrives, so in a row wider than
// one pixel the first pixel gives no result and the last gives two; a
// one-pixel row gives one. Over a row the count matches.
// A pixel's results are registered into the result queue when the pixel is
// taken. The block takes one pixel per clock while the four-entry result
// queue has room: it accepts a pixel whenever it has two free entries.
// When the receiver stalls the queue fills and req_tready drops; nothing is
// lost. Reset empties the queue and clears the shelf cursor to the top left.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_blit
   import gasb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // glyph_width [9:0], glyph_rows [19:10], coverage [27:20], zero [31:28]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_x [9:0], pixel_y [19:10], soft_alpha [27:20], origin_x [36:28],
   // origin_y [45:37], zero [47:46]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // no_room [0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic         take;
   logic         room_for_two;
   step_out_type step_out;
   result_type   head;

   assign req_tready = room_for_two;
   assign take       = req_tvalid && req_tready;

   gasb_place_step u_place_step (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .glyph_width (req_tdata[9:0]),
      .glyph_rows  (req_tdata[19:10]),
      .coverage    (req_tdata[27:20]),
      .step_out    (step_out)
   );

   gasb_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (take),
      .step_out     (step_out),
      .pop          (rsp_tvalid && rsp_tready),
      .room_for_two (room_for_two),
      .head_valid   (rsp_tvalid),
      .head         (head)
   );

   assign rsp_tdata = {2'b00, head.origin_y, head.origin_x, head.soft_alpha,
                       head.pixel_y, head.pixel_x};
   assign rsp_tuser = head.no_room;
   assign rsp_tlast = head.glyph_done;

endmodule

/* hw/rtl/gasb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasb_checker
// Port-level checks of the glyph atlas shelf blitter, bound to the top level.
// ----------------------------------------------------------------------------
module gasb_checker
   import gasb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast
);

   logic unused_ok;
   assign unused_ok = req_tvalid ^ req_tready ^ (^req_tdata);

   // queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast) &&
                                    $stable(rsp_tuser))
      else $error("stalled result changed");

   // a placed glyph never wraps: pixels sit at or right/below the origin
   a_inside_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[9:0] >= {1'b0, rsp_tdata[36:28]} &&
         rsp_tdata[19:10] >= {1'b0, rsp_tdata[45:37]})
      else $error("pixel outside its placed glyph");

   // a glyph's last pixel sits on the right edge, which always halves strong coverage
   a_last_softened: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[27:20] <= 8'd127)
      else $error("last pixel of a glyph not softened");

endmodule

bind glyph_atlas_shelf_blit gasb_checker u_gasb_checker (.*);
